>>> design/olr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olr_pkg
// Shared constants, types and helpers of the overlay line rasterizer.
// ----------------------------------------------------------------------------
package olr_pkg;

	localparam int FB_WIDTH     = 512;
	localparam int FB_HEIGHT    = 256;
	localparam int NUM_CHANNELS = 5;
	localparam int COLOR_BITS   = 8;

	localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int ADDR_W   = $clog2(FB_DEPTH);
	localparam int X_W      = 9;
	localparam int Y_W      = 8;
	localparam int D_W      = (X_W > Y_W) ? X_W : Y_W;
	localparam int CNT_W    = 10;
	localparam int CH_W     = 3;
	localparam int REQ_W    = 2;
	localparam int SET_W    = NUM_CHANNELS * COLOR_BITS;
	localparam int CFG_DW   = 64;
	localparam int CFG_AW   = 6;
	localparam int REG_IW   = 3;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEG  = 2'd2;

	localparam logic [REG_IW-1:0] REG_GRID_LINE = 3'd0;
	localparam logic [REG_IW-1:0] REG_GRID_BACK = 3'd1;
	localparam logic [REG_IW-1:0] REG_LINE_T0   = 3'd2;
	localparam logic [REG_IW-1:0] REG_LINE_T1   = 3'd3;
	localparam logic [REG_IW-1:0] REG_LINE_OV   = 3'd4;
	localparam logic [REG_IW-1:0] REG_BACK_T0   = 3'd5;
	localparam logic [REG_IW-1:0] REG_BACK_T1   = 3'd6;
	localparam logic [REG_IW-1:0] REG_BACK_OV   = 3'd7;

	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [SET_W-1:0]      color_set_reg_t;
	typedef logic [ADDR_W-1:0]     pix_addr_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_READ,
		OP_POINT
	} mem_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RWAIT,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		color_t         grid_line;
		color_t         grid_back;
		color_set_reg_t line_t0;
		color_set_reg_t line_t1;
		color_set_reg_t line_ov;
		color_set_reg_t back_t0;
		color_set_reg_t back_t1;
		color_set_reg_t back_ov;
	} cfg_t;

	typedef struct packed {
		color_t gl;
		color_t gb;
		color_t l0;
		color_t l1;
		color_t lf;
		color_t b0;
		color_t b1;
		color_t bf;
	} color_set_t;

	typedef struct packed {
		logic       erase;
		logic       trace;
		color_set_t colors;
	} draw_mode_t;

	typedef struct packed {
		logic      vld;
		mem_op_t   op;
		pix_addr_t addr;
		color_t    data;
	} mem_cmd_t;

	typedef struct packed {
		logic   vld;
		logic   is_read;
		logic   hit;
		color_t data;
	} mem_rsp_t;

	function automatic color_t set_code(color_set_reg_t r, logic [CH_W-1:0] ch);
		color_t c;
		c = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (int'(ch) == i) c = r[i*COLOR_BITS +: COLOR_BITS];
		end
		return c;
	endfunction

	function automatic logic on_store(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		return (int'(x) < FB_WIDTH) && (int'(y) < FB_HEIGHT);
	endfunction

	function automatic pix_addr_t pix_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		pix_addr_t row_base;
		row_base = ADDR_W'(ADDR_W'(y) * ADDR_W'(FB_WIDTH));
		return row_base + ADDR_W'(x);
	endfunction

endpackage

>>> design/overlay_line_rasterizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlay_line_rasterizer_core
// Frame store of color codes with pixel load/read and overlaid trace segment
// draw/erase by integer DDA, one read-modify-write per point.
//
//  port group   direction  handshake                 payload
//  request      in         start & !busy             req_type .. channel
//  result       out        done (one cycle, no hold) read_color, points_changed
//  config       in/out     APB, psel&penable&pwrite  paddr, pwdata, prdata
//
// busy states after acceptance: load EXEC, DONE; read EXEC, RWAIT, DONE;
// segment EXEC, WALK, DRAIN, DONE. The walk does one frame store RMW per
// point, pipelined over the one-read one-write memory with write forwarding.
// Reset clears control and registers; the frame store is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module overlay_line_rasterizer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [olr_pkg::REQ_W-1:0]    req_type,
	input  logic [olr_pkg::X_W-1:0]      x_start,
	input  logic [olr_pkg::Y_W-1:0]      y_start,
	input  logic [olr_pkg::X_W-1:0]      x_end,
	input  logic [olr_pkg::Y_W-1:0]      y_end,
	input  logic [olr_pkg::COLOR_BITS-1:0] load_color,
	input  logic                         erase,
	input  logic                         trace_sel,
	input  logic [olr_pkg::CH_W-1:0]     channel,
	output logic                         done,
	output logic [olr_pkg::COLOR_BITS-1:0] read_color,
	output logic [olr_pkg::CNT_W-1:0]    points_changed,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [olr_pkg::CFG_AW-1:0]   paddr,
	input  logic [olr_pkg::CFG_DW-1:0]   pwdata,
	output logic [olr_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready
);
	import olr_pkg::*;

	ctrl_state_t      state_q, state_d;

	logic [REQ_W-1:0] req_q;
	logic [X_W-1:0]   xs_q, xe_q;
	logic [Y_W-1:0]   ys_q, ye_q;
	color_t           lc_q;
	logic             erase_q, trace_q;
	logic [CH_W-1:0]  ch_q;

	color_t           read_color_q;
	logic [CNT_W-1:0] pts_q;

	logic             accept;
	cfg_t             cfg;
	draw_mode_t       mode;
	mem_cmd_t         cmd;
	mem_rsp_t         rsp;
	logic             walk_init, walk_step, walk_last;
	logic [X_W-1:0]   px;
	logic [Y_W-1:0]   py;

	olr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	olr_dda_walker u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.init    (walk_init),
		.step    (walk_step),
		.x_start (xs_q),
		.y_start (ys_q),
		.x_end   (xe_q),
		.y_end   (ye_q),
		.px      (px),
		.py      (py),
		.last    (walk_last)
	);

	olr_pixel_rmw u_rmw (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mode   (mode),
		.rsp    (rsp)
	);

	assign busy           = state_q != ST_IDLE;
	assign accept         = start && !busy;
	assign done           = state_q == ST_DONE;
	assign read_color     = read_color_q;
	assign points_changed = pts_q;

	always_comb begin
		mode.erase     = erase_q;
		mode.trace     = trace_q;
		mode.colors.gl = cfg.grid_line;
		mode.colors.gb = cfg.grid_back;
		mode.colors.l0 = set_code(cfg.line_t0, ch_q);
		mode.colors.l1 = set_code(cfg.line_t1, ch_q);
		mode.colors.lf = set_code(cfg.line_ov, ch_q);
		mode.colors.b0 = set_code(cfg.back_t0, ch_q);
		mode.colors.b1 = set_code(cfg.back_t1, ch_q);
		mode.colors.bf = set_code(cfg.back_ov, ch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		walk_init = 1'b0;
		walk_step = 1'b0;
		cmd.vld   = 1'b0;
		cmd.op    = OP_READ;
		cmd.addr  = pix_addr(xs_q, ys_q);
		cmd.data  = lc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (req_q)
					REQ_LOAD: begin
						cmd.vld = on_store(xs_q, ys_q);
						cmd.op  = OP_LOAD;
					end
					REQ_READ: begin
						cmd.vld = on_store(xs_q, ys_q);
						state_d = ST_RWAIT;
					end
					REQ_SEG: begin
						if (int'(ch_q) < NUM_CHANNELS) begin
							walk_init = 1'b1;
							state_d   = ST_WALK;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_RWAIT: state_d = ST_DONE;
			ST_WALK: begin
				walk_step = 1'b1;
				cmd.vld   = on_store(px, py);
				cmd.op    = OP_POINT;
				cmd.addr  = pix_addr(px, py);
				if (walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			xs_q    <= x_start;
			ys_q    <= y_start;
			xe_q    <= x_end;
			ye_q    <= y_end;
			lc_q    <= load_color;
			erase_q <= erase;
			trace_q <= trace_sel;
			ch_q    <= channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_color_q <= '0;
			pts_q        <= '0;
		end else if (accept) begin
			read_color_q <= '0;
			pts_q        <= '0;
		end else if (rsp.vld) begin
			if (rsp.is_read) read_color_q <= rsp.data;
			if (rsp.hit)     pts_q        <= pts_q + CNT_W'(1);
		end
	end

endmodule

>>> design/olr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olr_cfg_regs
// APB register file: grid codes and per-channel trace color sets.
// ----------------------------------------------------------------------------
module olr_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [olr_pkg::CFG_AW-1:0] paddr,
	input  logic [olr_pkg::CFG_DW-1:0] pwdata,
	output logic [olr_pkg::CFG_DW-1:0] prdata,
	output logic                      pready,
	output olr_pkg::cfg_t             cfg
);
	import olr_pkg::*;

	logic              wr_en;
	logic [REG_IW-1:0] idx;
	cfg_t              cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[CFG_AW-1:CFG_AW-REG_IW];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_GRID_LINE: cfg_q.grid_line <= pwdata[COLOR_BITS-1:0];
				REG_GRID_BACK: cfg_q.grid_back <= pwdata[COLOR_BITS-1:0];
				REG_LINE_T0:   cfg_q.line_t0   <= pwdata[SET_W-1:0];
				REG_LINE_T1:   cfg_q.line_t1   <= pwdata[SET_W-1:0];
				REG_LINE_OV:   cfg_q.line_ov   <= pwdata[SET_W-1:0];
				REG_BACK_T0:   cfg_q.back_t0   <= pwdata[SET_W-1:0];
				REG_BACK_T1:   cfg_q.back_t1   <= pwdata[SET_W-1:0];
				REG_BACK_OV:   cfg_q.back_ov   <= pwdata[SET_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GRID_LINE: prdata = CFG_DW'(cfg_q.grid_line);
			REG_GRID_BACK: prdata = CFG_DW'(cfg_q.grid_back);
			REG_LINE_T0:   prdata = CFG_DW'(cfg_q.line_t0);
			REG_LINE_T1:   prdata = CFG_DW'(cfg_q.line_t1);
			REG_LINE_OV:   prdata = CFG_DW'(cfg_q.line_ov);
			REG_BACK_T0:   prdata = CFG_DW'(cfg_q.back_t0);
			REG_BACK_T1:   prdata = CFG_DW'(cfg_q.back_t1);
			REG_BACK_OV:   prdata = CFG_DW'(cfg_q.back_ov);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> design/olr_dda_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olr_dda_walker
// Integer DDA point generator: distance+2 points, start point twice.
// ----------------------------------------------------------------------------
module olr_dda_walker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      init,
	input  logic                      step,
	input  logic [olr_pkg::X_W-1:0]   x_start,
	input  logic [olr_pkg::Y_W-1:0]   y_start,
	input  logic [olr_pkg::X_W-1:0]   x_end,
	input  logic [olr_pkg::Y_W-1:0]   y_end,
	output logic [olr_pkg::X_W-1:0]   px,
	output logic [olr_pkg::Y_W-1:0]   py,
	output logic                      last
);
	import olr_pkg::*;

	logic             xneg, yneg;
	logic [X_W-1:0]   adx;
	logic [Y_W-1:0]   ady;
	logic [D_W-1:0]   span;

	logic [X_W-1:0]   cx_q;
	logic [Y_W-1:0]   cy_q;
	logic [D_W-1:0]   ex_q, ey_q, adx_q, ady_q, d_q;
	logic             xneg_q, yneg_q;
	logic [CNT_W-1:0] t_q;

	logic [D_W:0]     ex_sum, ey_sum;
	logic             ex_over, ey_over;

	always_comb begin
		xneg = x_end < x_start;
		yneg = y_end < y_start;
		adx  = xneg ? (x_start - x_end) : (x_end - x_start);
		ady  = yneg ? (y_start - y_end) : (y_end - y_start);
		span = (D_W'(adx) > D_W'(ady)) ? D_W'(adx) : D_W'(ady);
	end

	assign ex_sum  = {1'b0, ex_q} + {1'b0, adx_q};
	assign ey_sum  = {1'b0, ey_q} + {1'b0, ady_q};
	assign ex_over = ex_sum > {1'b0, d_q};
	assign ey_over = ey_sum > {1'b0, d_q};

	assign px   = cx_q;
	assign py   = cy_q;
	assign last = t_q == (CNT_W'(d_q) + CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (init) begin
			t_q <= '0;
		end else if (step) begin
			t_q <= t_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			cx_q   <= x_start;
			cy_q   <= y_start;
			ex_q   <= '0;
			ey_q   <= '0;
			adx_q  <= D_W'(adx);
			ady_q  <= D_W'(ady);
			d_q    <= span;
			xneg_q <= xneg;
			yneg_q <= yneg;
		end else if (step) begin
			if (ex_over) begin
				ex_q <= D_W'(ex_sum - {1'b0, d_q});
				cx_q <= xneg_q ? (cx_q - X_W'(1)) : (cx_q + X_W'(1));
			end else begin
				ex_q <= D_W'(ex_sum);
			end
			if (ey_over) begin
				ey_q <= D_W'(ey_sum - {1'b0, d_q});
				cy_q <= yneg_q ? (cy_q - Y_W'(1)) : (cy_q + Y_W'(1));
			end else begin
				ey_q <= D_W'(ey_sum);
			end
		end
	end

endmodule

>>> design/olr_pixel_rmw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olr_pixel_rmw
// Frame store with a registered read and a pipelined read-modify-write path.
// The last write is forwarded to a read of the same pixel issued alongside it.
// ----------------------------------------------------------------------------
module olr_pixel_rmw (
	input  logic                  clk,
	input  logic                  arst_n,
	input  olr_pkg::mem_cmd_t     cmd,
	input  olr_pkg::draw_mode_t   mode,
	output olr_pkg::mem_rsp_t     rsp
);
	import olr_pkg::*;

	color_t    store [FB_DEPTH];

	color_t    rdata_s1;
	logic      vld_s1;
	mem_op_t   op_s1;
	pix_addr_t addr_s1;

	logic      wr_vld_q;
	pix_addr_t wr_addr_q;
	color_t    wr_data_q;

	color_t    old;
	color_t    nv;
	logic      hit;
	logic      we;
	pix_addr_t wa;
	color_t    wd;

	function automatic logic [COLOR_BITS:0] next_color(color_t o, logic ers, logic tr,
			color_set_t c);
		logic   h;
		color_t n;
		h = 1'b1;
		n = o;
		if (!ers) begin
			priority if (o == c.gl)        n = tr ? c.l1 : c.l0;
			else if (o == c.gb)            n = tr ? c.b1 : c.b0;
			else if (o == c.l0 && tr)      n = c.lf;
			else if (o == c.l1 && !tr)     n = c.lf;
			else if (o == c.b0 && tr)      n = c.bf;
			else if (o == c.b1 && !tr)     n = c.bf;
			else                           h = 1'b0;
		end else begin
			priority if (o == c.b0 && !tr) n = c.gb;
			else if (o == c.b1 && tr)      n = c.gb;
			else if (o == c.l0 && !tr)     n = c.gl;
			else if (o == c.l1 && tr)      n = c.gl;
			else if (o == c.lf)            n = tr ? c.l0 : c.l1;
			else if (o == c.bf)            n = tr ? c.b0 : c.b1;
			else                           h = 1'b0;
		end
		return {h, n};
	endfunction

	assign old = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_s1;

	always_comb begin
		{hit, nv} = next_color(old, mode.erase, mode.trace, mode.colors);
		we = 1'b0;
		wa = cmd.addr;
		wd = cmd.data;
		if (vld_s1 && op_s1 == OP_POINT && hit) begin
			we = 1'b1;
			wa = addr_s1;
			wd = nv;
		end else if (cmd.vld && cmd.op == OP_LOAD) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) store[wa] <= wd;
		rdata_s1 <= store[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.vld && cmd.op != OP_LOAD;
			if (we) wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= cmd.op;
		addr_s1 <= cmd.addr;
		if (we) begin
			wr_addr_q <= wa;
			wr_data_q <= wd;
		end
	end

	assign rsp.vld     = vld_s1;
	assign rsp.is_read = op_s1 == OP_READ;
	assign rsp.hit     = op_s1 == OP_POINT && hit;
	assign rsp.data    = old;

endmodule
